FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/owtsc_pkg.sv
package owtsc_pkg;

	// request kinds on the input tuser
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_NAK  = 1'b1;

	// register indexes on the config port
	localparam logic REG_ERROR_LIMIT = 1'b0;

	localparam logic [3:0] LAST_BYTE   = 4'd8;
	localparam logic [3:0] FAIL_MAX    = 4'd15;
	localparam logic [3:0] LIMIT_RESET = 4'd3;
	localparam logic [7:0] CRC_POLY    = 8'h8C;
	localparam logic [7:0] ALL_ONES    = 8'hFF;

	typedef enum logic [1:0] {
		KIND_KEEP    = 2'd0,
		KIND_NEW     = 2'd1,
		KIND_UNKNOWN = 2'd2
	} kind_t;

	// state carried across the bytes of one read
	typedef struct packed {
		logic [3:0] byte_index;
		logic [7:0] crc;
		logic [7:0] temp_low;
		logic [7:0] temp_high;
		logic [3:0] fail_count;
	} rd_state_t;

	typedef struct packed {
		kind_t             kind;
		logic signed [11:0] temperature;
		logic [7:0]        crc_calc;
		logic [3:0]        error_count;
	} result_t;

	// reflected crc-8 over one byte, lsb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/owtsc_step.sv
module owtsc_step (
	input  owtsc_pkg::rd_state_t state,
	input  logic                 req_type,
	input  logic [7:0]           data_byte,
	input  logic [3:0]           error_limit,
	output owtsc_pkg::rd_state_t state_next,
	output logic                 res_valid,
	output owtsc_pkg::result_t   res
);

	logic [3:0]  fail_inc;
	logic        at_limit;
	logic        read_good;
	logic [11:0] temp_dec;

	// failure count with saturation and limit check
	assign fail_inc = (state.fail_count == owtsc_pkg::FAIL_MAX) ? owtsc_pkg::FAIL_MAX
		: state.fail_count + 4'd1;
	assign at_limit = (fail_inc >= error_limit);

	// a read is good when crc matches and the data is not all ones
	assign read_good = !((state.temp_low == owtsc_pkg::ALL_ONES)
		&& (state.temp_high == owtsc_pkg::ALL_ONES)) && (state.crc == data_byte);

	// 11 magnitude bits, minus 2048 when any upper bit of byte 1 is set
	assign temp_dec = {|state.temp_high[7:3], state.temp_high[2:0], state.temp_low};

	// next state and result
	always_comb begin
		state_next      = state;
		res_valid       = 1'b0;
		res.kind        = owtsc_pkg::KIND_KEEP;
		res.temperature = '0;
		res.crc_calc    = '0;
		res.error_count = '0;
		if (req_type == owtsc_pkg::REQ_NAK) begin
			state_next.byte_index = '0;
			state_next.crc        = '0;
			state_next.fail_count = at_limit ? 4'd0 : fail_inc;
			res_valid             = 1'b1;
			res.kind              = at_limit ? owtsc_pkg::KIND_UNKNOWN : owtsc_pkg::KIND_KEEP;
			res.error_count       = state_next.fail_count;
		end else if (state.byte_index < owtsc_pkg::LAST_BYTE) begin
			if (state.byte_index == 4'd0) begin
				state_next.temp_low = data_byte;
			end
			if (state.byte_index == 4'd1) begin
				state_next.temp_high = data_byte;
			end
			state_next.crc        = owtsc_pkg::crc8_byte(state.crc, data_byte);
			state_next.byte_index = state.byte_index + 4'd1;
		end else begin
			state_next.byte_index = '0;
			state_next.crc        = '0;
			res_valid             = 1'b1;
			res.crc_calc          = state.crc;
			if (read_good) begin
				state_next.fail_count = '0;
				res.kind              = owtsc_pkg::KIND_NEW;
				res.temperature       = temp_dec;
			end else begin
				state_next.fail_count = at_limit ? 4'd0 : fail_inc;
				res.kind              = at_limit ? owtsc_pkg::KIND_UNKNOWN
					: owtsc_pkg::KIND_KEEP;
			end
			res.error_count = state_next.fail_count;
		end
	end

endmodule

FILE: rtl/core/onewire_temp_scratchpad_check_unit.sv
// a result is registered and appears on the master side in the cycle after the beat that causes it
// throughput: one input beat per cycle while the output is not stalled; bytes 0 to 7 of a read give no result
// the byte-wide crc update and result decode sit between the read state and output register
// input is taken whenever the output register is empty or being drained
// reset (arst_n low, asynchronous): read state and failure count clear, error_limit
// returns to 3, no result pending
module onewire_temp_scratchpad_check_unit (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] req_type
	// stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [11:0] temperature, [19:12] crc_calc, [23:20] error_count
	output logic [1:0]  m_axis_tuser,   // [1:0] update_kind
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	owtsc_pkg::rd_state_t state_q;
	owtsc_pkg::rd_state_t state_next;
	owtsc_pkg::result_t   res_next;
	owtsc_pkg::result_t   res_q;
	logic                 res_valid_next;
	logic                 out_valid_q;
	logic [3:0]           error_limit_q;
	logic                 in_beat;
	logic                 cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[2] == owtsc_pkg::REG_ERROR_LIMIT);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q <= owtsc_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			error_limit_q <= pwdata[3:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr[2] == owtsc_pkg::REG_ERROR_LIMIT) begin
			prdata = {28'd0, error_limit_q};
		end
	end

	// input handshake
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	owtsc_step u_step (
		.state       (state_q),
		.req_type    (s_axis_tuser),
		.data_byte   (s_axis_tdata),
		.error_limit (error_limit_q),
		.state_next  (state_next),
		.res_valid   (res_valid_next),
		.res         (res_next)
	);

	// read state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_beat) begin
			state_q <= state_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= res_valid_next;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_beat && res_valid_next) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.error_count, res_q.crc_calc, res_q.temperature};
	assign m_axis_tuser  = res_q.kind;

	// checks
	`ASSERT_IMPLIES(a_index_range, clk, arst_n, 1'b1,
		state_q.byte_index <= owtsc_pkg::LAST_BYTE)
	`ASSERT_NEXT(a_nak_gives_result, clk, arst_n,
		in_beat && (s_axis_tuser == owtsc_pkg::REQ_NAK), m_axis_tvalid)
	`ASSERT_IMPLIES(a_good_clears_count, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser != owtsc_pkg::KIND_KEEP), m_axis_tdata[23:20] == 4'd0)
	`ASSERT_IMPLIES(a_temp_only_when_new, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser != owtsc_pkg::KIND_NEW), m_axis_tdata[11:0] == 12'd0)

endmodule
